// File: rtl/decimal_text_to_fixed_defines.svh
// Assertion macros shared by the checker of decimal_text_to_fixed.
`ifndef DECIMAL_TEXT_TO_FIXED_DEFINES_SVH
`define DECIMAL_TEXT_TO_FIXED_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DTF_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("decimal_text_to_fixed assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DTF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("decimal_text_to_fixed assertion failed");

`endif

// File: rtl/dtf_pkg.sv
// Shared types, constants and constant functions of the decimal text parser.
`timescale 1ns / 1ps
package dtf_pkg;

    localparam int MAX_DIGITS_DEF = 18;
    localparam int FRAC_BITS_DEF  = 24;

    // Mantissa holds up to 10^18 - 1.
    localparam int MANT_W    = 60;
    localparam int FCNT_W    = 5;
    // Largest divisor is 10^31, below 2^103.
    localparam int DEN_W     = 104;
    localparam int POW_COUNT = 32;

    localparam logic [FCNT_W-1:0] FRAC_CAP = 5'd31;

    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    localparam logic [63:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] VAL_MIN = 64'h8000_0000_0000_0000;

    typedef enum logic [2:0] {
        PH_SPACE = 3'd0,
        PH_SIGN  = 3'd1,
        PH_INT   = 3'd2,
        PH_FRAC  = 3'd3,
        PH_DONE  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        CT_PARSE  = 2'd0,
        CT_LOAD   = 2'd1,
        CT_DIVIDE = 2'd2,
        CT_EMIT   = 2'd3
    } ctl_state_t;

    typedef struct packed {
        logic take;   // parse the accepted character
        logic load;   // load the divider from the mantissa
        logic step;   // one restoring-division step
        logic emit;   // write the result register and clear the parser
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    typedef logic [POW_COUNT-1:0][DEN_W-1:0] pow_tab_t;

    function automatic pow_tab_t pow10_table();
        pow_tab_t         tab;
        logic [DEN_W-1:0] p;
        p = DEN_W'(1);
        for (int i = 0; i < POW_COUNT; i++) begin
            tab[i] = p;
            p = p * DEN_W'(10);
        end
        return tab;
    endfunction

    function automatic logic [63:0] mant_limit(int digits);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < digits; i++) begin
            p = p * 64'd10;
        end
        return p - 64'd1;
    endfunction

endpackage

// File: rtl/dtf_ctrl.sv
// Controller state machine: input handshake, division step count, result hand-off.
`timescale 1ns / 1ps
module dtf_ctrl #(
    parameter int FRAC_BITS = dtf_pkg::FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_last,
    input  dtf_pkg::dp_status_t status,
    output dtf_pkg::dp_cmd_t    cmd
);
    import dtf_pkg::*;

    localparam int DIV_STEPS = MANT_W + FRAC_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    ctl_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CT_PARSE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            CT_PARSE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
                if (s_valid && s_last) begin
                    state_next = CT_LOAD;
                end
            end
            CT_LOAD: begin
                cmd.load   = 1'b1;
                cnt_next   = CNT_W'(DIV_STEPS - 1);
                state_next = CT_DIVIDE;
            end
            CT_DIVIDE: begin
                cmd.step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = CT_EMIT;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            CT_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = CT_PARSE;
                end
            end
            default: begin
                state_next = CT_PARSE;
            end
        endcase
    end

endmodule

// File: rtl/dtf_datapath.sv
// Datapath: character parser, mantissa, restoring divider and saturating result register.
`timescale 1ns / 1ps
module dtf_datapath #(
    parameter int MAX_DIGITS = dtf_pkg::MAX_DIGITS_DEF,
    parameter int FRAC_BITS  = dtf_pkg::FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          s_character,
    input  dtf_pkg::dp_cmd_t    cmd,
    output dtf_pkg::dp_status_t status,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [63:0]  m_value,
    output logic                m_overflow
);
    import dtf_pkg::*;

    localparam int          DIV_W   = MANT_W + FRAC_BITS;
    localparam logic [63:0] LIMIT   = mant_limit(MAX_DIGITS);
    localparam pow_tab_t    POW_TAB = pow10_table();

    // Parser state
    phase_t              phase_reg, phase_next;
    logic [MANT_W-1:0]   mant_reg, mant_next;
    logic [FCNT_W-1:0]   frac_reg, frac_next;
    logic                neg_reg, neg_next;
    logic                sat_reg, sat_next;

    // Divider
    logic [DIV_W-1:0]    quo_reg, quo_next;
    logic [DEN_W-1:0]    rem_reg, rem_next;
    logic [DEN_W-1:0]    den_reg, den_next;

    // Result register
    logic                m_valid_reg, m_valid_next;
    logic [63:0]         m_value_reg, m_value_next;
    logic                m_overflow_reg, m_overflow_next;

    logic                is_digit, is_space, is_sign, int_path, take_digit, frac_digit;
    logic [63:0]         mant_wide, prod;
    logic [DEN_W:0]      trial, diff;
    logic [127:0]        q_ext;
    logic                hi_nz;
    logic [63:0]         lo;

    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_value         = m_value_reg;
    assign m_overflow      = m_overflow_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SPACE;
            mant_reg    <= '0;
            frac_reg    <= '0;
            neg_reg     <= 1'b0;
            sat_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            mant_reg    <= mant_next;
            frac_reg    <= frac_next;
            neg_reg     <= neg_next;
            sat_reg     <= sat_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        den_reg        <= den_next;
        m_value_reg    <= m_value_next;
        m_overflow_reg <= m_overflow_next;
    end

    // Character classes and the digit append product; its range check is in the parser
    always_comb begin
        is_digit  = (s_character >= CH_ZERO) && (s_character <= CH_NINE);
        is_space  = ((s_character >= CH_TAB) && (s_character <= CH_CR))
                    || (s_character == CH_SPACE);
        is_sign   = (s_character == CH_PLUS) || (s_character == CH_MINUS);
        mant_wide = 64'(mant_reg);
        prod      = (mant_wide << 3) + (mant_wide << 1) + 64'(s_character[3:0]);
        int_path  = ((phase_reg == PH_SPACE) && !is_space && !is_sign)
                    || (phase_reg == PH_SIGN) || (phase_reg == PH_INT);
    end

    // Parser
    always_comb begin
        phase_next = phase_reg;
        mant_next  = mant_reg;
        frac_next  = frac_reg;
        neg_next   = neg_reg;
        sat_next   = sat_reg;
        take_digit = 1'b0;
        frac_digit = 1'b0;

        if (cmd.take) begin
            if (int_path) begin
                if (is_digit) begin
                    phase_next = PH_INT;
                    take_digit = 1'b1;
                end else if (s_character == CH_DOT) begin
                    phase_next = PH_FRAC;
                end else begin
                    phase_next = PH_DONE;
                end
            end else if (phase_reg == PH_SPACE) begin
                if (is_sign) begin
                    neg_next   = (s_character == CH_MINUS);
                    phase_next = PH_SIGN;
                end
            end else if (phase_reg == PH_FRAC) begin
                if (is_digit) begin
                    take_digit = (frac_reg != FRAC_CAP);
                    frac_digit = 1'b1;
                end else begin
                    phase_next = PH_DONE;
                end
            end
        end

        if (take_digit && !sat_reg) begin
            if (prod > LIMIT) begin
                sat_next = 1'b1;
            end else begin
                mant_next = prod[MANT_W-1:0];
                if (frac_digit) begin
                    frac_next = frac_reg + 1'b1;
                end
            end
        end

        // Drop the parsed string once its result is stored
        if (cmd.emit) begin
            phase_next = PH_SPACE;
            mant_next  = '0;
            frac_next  = '0;
            neg_next   = 1'b0;
            sat_next   = 1'b0;
        end
    end

    // Restoring division of mantissa * 2^FRAC_BITS by 10^fraction_digits
    always_comb begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        trial    = {rem_reg, quo_reg[DIV_W-1]};
        diff     = trial - {1'b0, den_reg};
        if (cmd.load) begin
            quo_next = DIV_W'(mant_reg) << FRAC_BITS;
            rem_next = '0;
            den_next = POW_TAB[frac_reg];
        end else if (cmd.step) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = diff[DEN_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    // Sign, saturation and the output register
    always_comb begin
        q_ext           = {{(128 - DIV_W){1'b0}}, quo_reg};
        hi_nz           = |q_ext[127:64];
        lo              = q_ext[63:0];
        m_value_next    = m_value_reg;
        m_overflow_next = m_overflow_reg;
        m_valid_next    = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.emit) begin
            m_valid_next = 1'b1;
            if (sat_reg) begin
                m_overflow_next = 1'b1;
                m_value_next    = neg_reg ? VAL_MIN : VAL_MAX;
            end else if (neg_reg) begin
                if (hi_nz || (lo > VAL_MIN)) begin
                    m_overflow_next = 1'b1;
                    m_value_next    = VAL_MIN;
                end else begin
                    m_overflow_next = 1'b0;
                    m_value_next    = 64'd0 - lo;
                end
            end else begin
                if (hi_nz || lo[63]) begin
                    m_overflow_next = 1'b1;
                    m_value_next    = VAL_MAX;
                end else begin
                    m_overflow_next = 1'b0;
                    m_value_next    = lo;
                end
            end
        end
    end

endmodule

// File: rtl/decimal_text_to_fixed.sv
// Top level of the decimal text to signed fixed-point converter.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  s_      | in        | s_valid / s_ready  | s_character[7:0], s_last
//  m_      | out       | m_valid / m_ready  | m_value[63:0] signed, m_overflow
//
// Characters are taken while the parser is open. A transaction with s_last set
// is parsed, then the divider loads, runs MANT_W + FRAC_BITS restoring steps
// (84 with the defaults), and writes the result once the result register is free.
// The divider yields 60 + FRAC_BITS quotient bits, one bit per cycle.
// Reset (aresetn low, synchronous) returns to whitespace skipping with no result pending.
// The result register holds a finished value while m_ready is low; parsing of
// the next string goes on meanwhile, and only the final write waits for it.
`timescale 1ns / 1ps
module decimal_text_to_fixed #(
    parameter int MAX_DIGITS = dtf_pkg::MAX_DIGITS_DEF,
    parameter int FRAC_BITS  = dtf_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_character,
    input  logic               s_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [63:0] m_value,
    output logic               m_overflow
);
    import dtf_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequence parse, divider load, division steps and result write
    dtf_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_last  (s_last),
        .status  (status),
        .cmd     (cmd)
    );

    // Hold parser state, mantissa, divider and the result register
    dtf_datapath #(
        .MAX_DIGITS (MAX_DIGITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_character (s_character),
        .cmd         (cmd),
        .status      (status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_overflow  (m_overflow)
    );

endmodule

// File: rtl/dtf_checker.sv
// Port-level checker of decimal_text_to_fixed and its bind.
`timescale 1ns / 1ps
`include "decimal_text_to_fixed_defines.svh"
module dtf_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [7:0]         s_character,
    input logic               s_last,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [63:0] m_value,
    input logic               m_overflow
);

    // A stalled result holds
    `DTF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
                     m_valid && $stable(m_value) && $stable(m_overflow))

    // The final character starts the divider, so input closes right after it
    `DTF_ASSERT_NEXT(a_last_closes, aclk, aresetn, s_valid && s_ready && s_last, !s_ready)

    // A result is written only while input is closed
    `DTF_ASSERT_NOW(a_rise_closed, aclk, aresetn, $rose(m_valid), !$past(s_ready))

    // Overflow always comes with a saturated value
    `DTF_ASSERT_NOW(a_ovf_sat, aclk, aresetn, m_valid && m_overflow,
                    (m_value == 64'sh7FFF_FFFF_FFFF_FFFF) || (m_value == 64'sh8000_0000_0000_0000))

endmodule

bind decimal_text_to_fixed dtf_checker u_dtf_checker (.*);

// File: tb/sv/testbench.sv
// Self-checking testbench for the decimal text to fixed-point converter.
`timescale 1ns / 1ps
module testbench;
    import dtf_pkg::*;

    localparam int MAX_DIGITS = MAX_DIGITS_DEF;
    localparam int FRAC_BITS  = FRAC_BITS_DEF;
    localparam int CLK_PERIOD = 12;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_CHARS = 1350;
    // Stop idling on both sides once this few characters remain.
    localparam int QUIET_TAIL = 150;
    // Give the drain ample margin beyond one result's parse, division and write.
    localparam int DRAIN_CYCLES = FRAC_BITS + 200;
    // Allow far more time than the slowest legal run needs.
    localparam longint TIMEOUT_NS = 40_000_000;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_item_t;

    typedef struct packed {
        logic signed [63:0] value;
        logic               overflow;
    } fixed_result_t;

    typedef logic [7:0] text_t[$];

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    logic [7:0]         s_character = 8'd0;
    logic               s_last      = 1'b0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    logic signed [63:0] m_value;
    logic               m_overflow;

    // Characters waiting to be driven, and fixed-point values still owed by the DUT.
    char_item_t    pending_chars[$];
    fixed_result_t expected_values[$];

    int errors         = 0;
    int total_chars    = 0;
    int accepted_chars = 0;
    int s_idle_left    = 0;
    int m_stall_left   = 0;
    int s_idle_pct     = 20;
    int m_idle_pct     = 20;

    // Parser shadow state
    phase_t            shadow_phase    = PH_SPACE;
    logic [MANT_W-1:0] shadow_mantissa = '0;
    logic [FCNT_W-1:0] shadow_frac_cnt = '0;
    logic              shadow_negative = 1'b0;
    logic              shadow_saturated = 1'b0;
    logic [63:0]       digit_limit;

    wire quiet_tail = (total_chars - accepted_chars) < QUIET_TAIL;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    decimal_text_to_fixed #(
        .MAX_DIGITS (MAX_DIGITS),
        .FRAC_BITS  (FRAC_BITS)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_character (s_character),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_overflow  (m_overflow)
    );

    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Idle percentage for the next stretch; zero gives runs with no gaps at all.
    function automatic int pick_idle_pct();
        case ($urandom_range(3))
            0: return 0;
            1: return 5;
            2: return 25;
            default: return 50;
        endcase
    endfunction

    function automatic logic is_digit_char(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // Accumulate one digit into the mantissa; drop it and all later ones once the
    // mantissa would pass the digit limit.
    task automatic accumulate_digit(input logic [7:0] c);
        logic [63:0] d;
        d = 64'(c - CH_ZERO);
        if (shadow_saturated) return;
        if (64'(shadow_mantissa) > (digit_limit - d) / 64'd10) begin
            shadow_saturated = 1'b1;
            return;
        end
        shadow_mantissa = MANT_W'(64'(shadow_mantissa) * 64'd10 + d);
        if (shadow_phase == PH_FRAC) shadow_frac_cnt++;
    endtask

    // floor(mantissa * 2^FRAC_BITS / 10^frac), signed and saturated to 64 bits.
    function automatic fixed_result_t scale_to_fixed();
        fixed_result_t r;
        logic [127:0]  num;
        logic [127:0]  den;
        logic [127:0]  quo;
        r.overflow = 1'b0;
        if (shadow_saturated) begin
            r.overflow = 1'b1;
            r.value    = shadow_negative ? VAL_MIN : VAL_MAX;
            return r;
        end
        num = 128'(shadow_mantissa) << FRAC_BITS;
        den = 128'd1;
        for (int k = 0; k < int'(shadow_frac_cnt); k++) den = den * 128'd10;
        quo = num / den;
        if (shadow_negative) begin
            if (quo > 128'(VAL_MIN)) begin
                r.overflow = 1'b1;
                r.value    = VAL_MIN;
            end else begin
                r.value = -quo[63:0];
            end
        end else begin
            if (quo > 128'(VAL_MAX)) begin
                r.overflow = 1'b1;
                r.value    = VAL_MAX;
            end else begin
                r.value = quo[63:0];
            end
        end
        return r;
    endfunction

    // Advance the shadow parser by one accepted character; on the last one
    // queue the expected value and return to whitespace skipping.
    task automatic predict_char(input logic [7:0] c, input logic last);
        logic lead;
        lead = shadow_phase == PH_SPACE || shadow_phase == PH_SIGN || shadow_phase == PH_INT;
        if (shadow_phase == PH_SPACE && ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE)) begin
            // skip whitespace
        end else if (shadow_phase == PH_SPACE && (c == CH_PLUS || c == CH_MINUS)) begin
            shadow_negative = (c == CH_MINUS);
            shadow_phase    = PH_SIGN;
        end else if (lead) begin
            if (is_digit_char(c)) begin
                shadow_phase = PH_INT;
                accumulate_digit(c);
            end else if (c == CH_DOT) begin
                shadow_phase = PH_FRAC;
            end else begin
                shadow_phase = PH_DONE;
            end
        end else if (shadow_phase == PH_FRAC) begin
            if (is_digit_char(c)) begin
                // fraction digits past the cap are dropped, which truncates
                if (shadow_frac_cnt < FRAC_CAP) accumulate_digit(c);
            end else begin
                shadow_phase = PH_DONE;
            end
        end
        if (last) begin
            expected_values.push_back(scale_to_fixed());
            shadow_phase     = PH_SPACE;
            shadow_mantissa  = '0;
            shadow_frac_cnt  = '0;
            shadow_negative  = 1'b0;
            shadow_saturated = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------
    function automatic text_t lit(input string s);
        text_t q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    // Queue one string; the final character carries the last flag.
    task automatic push_text(input text_t txt);
        for (int i = 0; i < txt.size(); i++) begin
            pending_chars.push_back('{ch: txt[i], last: (i == txt.size() - 1)});
        end
    endtask

    function automatic int pick_digit_count(input bit frac);
        int roll;
        roll = $urandom_range(99);
        if (frac) begin
            if (roll < 50) return $urandom_range(4);
            if (roll < 80) return $urandom_range(5, 12);
            return $urandom_range(13, 36);
        end
        if (roll < 70) return $urandom_range(4);
        if (roll < 90) return $urandom_range(5, 12);
        return $urandom_range(13, 20);
    endfunction

    // Append n digits; with zero_lead, all but the last few are zeros so long
    // fractions reach the fraction-digit cap without saturating the mantissa.
    task automatic append_digits(inout text_t txt, input int n, input bit zero_lead);
        int tail;
        tail = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
            if (zero_lead && i < n - tail) txt.push_back(CH_ZERO);
            else txt.push_back(8'(CH_ZERO + $urandom_range(9)));
        end
    endtask

    // Well-formed number text with random content, optional junk after it.
    task automatic build_number(output text_t txt);
        int    n;
        byte   ws_codes[6];
        ws_codes = '{8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'h20};
        txt = {};
        n = $urandom_range(3) == 0 ? $urandom_range(1, 3) : 0;
        for (int i = 0; i < n; i++) txt.push_back(ws_codes[$urandom_range(5)]);
        case ($urandom_range(2))
            0: txt.push_back(CH_PLUS);
            1: txt.push_back(CH_MINUS);
            default: ;
        endcase
        append_digits(txt, pick_digit_count(1'b0), $urandom_range(3) == 0);
        if ($urandom_range(99) < 60) begin
            txt.push_back(CH_DOT);
            append_digits(txt, pick_digit_count(1'b1), $urandom_range(9) < 3);
        end
        if ($urandom_range(1) == 1) begin
            // terminate with NUL or any byte, then trailing bytes that must be ignored
            txt.push_back($urandom_range(3) == 0 ? 8'h00 : 8'($urandom_range(255)));
            n = $urandom_range(3);
            for (int i = 0; i < n; i++) txt.push_back(8'($urandom_range(255)));
        end
        if (txt.size() == 0) txt.push_back(8'($urandom_range(255)));
    endtask

    // Broken sequences: random bytes mixed with number characters.
    task automatic build_noise(output text_t txt);
        text_t alphabet;
        int    n;
        alphabet = lit("+-. 0123456789");
        alphabet.push_back(CH_TAB);
        alphabet.push_back(8'h00);
        txt = {};
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(1) == 1) txt.push_back(8'($urandom_range(255)));
            else txt.push_back(alphabet[$urandom_range(alphabet.size() - 1)]);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: present queued characters, idle in random bursts between them
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        char_item_t item;
        logic       busy;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            busy = s_valid;
            if (s_valid && s_ready) begin
                predict_char(s_character, s_last);
                accepted_chars++;
                busy = 1'b0;
                // change the pace now and then so gaps land on every phase
                if (accepted_chars % 64 == 0) begin
                    s_idle_pct = pick_idle_pct();
                    m_idle_pct = pick_idle_pct();
                end
            end
            // hold the current transaction until it is taken
            if (!busy) begin
                if (s_idle_left > 0) begin
                    s_idle_left--;
                    s_valid <= 1'b0;
                end else if (pending_chars.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (!quiet_tail && $urandom_range(99) < s_idle_pct) begin
                    s_idle_left = $urandom_range(16);
                    s_valid <= 1'b0;
                end else begin
                    item = pending_chars.pop_front();
                    s_valid     <= 1'b1;
                    s_character <= item.ch;
                    s_last      <= item.last;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: stall m_ready in random bursts
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (m_stall_left > 0) begin
            m_stall_left--;
            m_ready <= 1'b0;
        end else if (!quiet_tail && $urandom_range(99) < m_idle_pct) begin
            m_stall_left = $urandom_range(16);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: compare each result transaction with the oldest expected value.
    always @(posedge aclk) begin
        fixed_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_values.size() == 0) begin
                report_mismatch($sformatf("unexpected result value %0d overflow %0b",
                                          m_value, m_overflow));
            end else begin
                want = expected_values.pop_front();
                if (m_value !== want.value)
                    report_mismatch($sformatf("value %0d, expected %0d", m_value, want.value));
                if (m_overflow !== want.overflow)
                    report_mismatch($sformatf("overflow %0b, expected %0b (value %0d)",
                                              m_overflow, want.overflow, want.value));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: build stimulus, reset, run, drain, judge
    // ------------------------------------------------------------------
    initial begin
        text_t txt;
        string boundary_texts[8];
        int    goal;
        boundary_texts = '{
            "549755813888", "-549755813888", "-549755813888.0000001",
            "549755813887.99999999", "0.000000059604644775390625",
            "999999999999999999", "-1234567890123456789",
            "0.0000000000000000000000000000001234"
        };

        digit_limit = 64'd1;
        for (int i = 0; i < MAX_DIGITS; i++) digit_limit = digit_limit * 64'd10;
        digit_limit = digit_limit - 64'd1;

        // Directed: every whitespace code, sign and negative zero
        txt = '{8'd9, 8'd10, 8'd11, 8'd12, CH_CR, CH_SPACE, CH_MINUS, CH_ZERO};
        push_text(txt);
        // top byte alone: non-numeric text gives zero
        push_text('{8'hFF});
        // NUL ends parsing, the digit after it is ignored
        txt = lit("+.5");
        txt.push_back(8'h00);
        txt.push_back(CH_SPACE + 8'd23);
        push_text(txt);
        // integer part just past 2^39 saturates the result
        push_text(lit("600000000000"));

        // Random: mostly well-formed numbers, some boundary values, some noise
        goal = pending_chars.size() + RANDOM_CHARS;
        while (pending_chars.size() < goal) begin
            case ($urandom_range(19))
                0:       push_text(lit(boundary_texts[$urandom_range(7)]));
                1, 2, 3: begin
                    build_noise(txt);
                    push_text(txt);
                end
                default: begin
                    build_number(txt);
                    push_text(txt);
                end
            endcase
        end
        total_chars = pending_chars.size();

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // wait until every character has been taken and every value returned
        while (accepted_chars < total_chars) @(posedge aclk);
        while (expected_values.size() > 0) @(posedge aclk);
        // let any stray result surface
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_values.size() > 0)
            report_mismatch($sformatf("%0d expected values never arrived",
                                      expected_values.size()));

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/dtf_pkg.sv
rtl/dtf_ctrl.sv
rtl/dtf_datapath.sv
rtl/decimal_text_to_fixed.sv
rtl/dtf_checker.sv
tb/sv/testbench.sv
